FILE: src/thread_run_queue_macros.svh
// assertion macros for the run queue
`ifndef THREAD_RUN_QUEUE_MACROS_SVH
`define THREAD_RUN_QUEUE_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define TRQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define TRQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/trq_pkg.sv
// shared constants and types of the run queue
`default_nettype none

package trq_pkg;

    localparam int THREADS = 256;
    localparam int ID_W    = $clog2(THREADS);
    localparam int OP_W    = 2;
    localparam int TID_W   = 8;
    localparam int LEN_W   = 8;
    localparam int IDLE_W  = 8;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_BACK  = 2'd0,
        OP_PUSH_FRONT = 2'd1,
        OP_SCHEDULE   = 2'd2
    } op_t;

    // clearing sweep towards the map write port
    typedef struct packed {
        logic            busy;
        logic            wr_en;
        logic [ID_W-1:0] addr;
    } clr_t;

endpackage

`default_nettype wire

FILE: src/trq_req_if.sv
// request channel of the run queue
`default_nettype none

interface trq_req_if;
    logic                      valid;
    logic                      ready;
    logic [trq_pkg::OP_W-1:0]  operation;
    logic [trq_pkg::TID_W-1:0] thread_id;

    modport source (output valid, output operation, output thread_id, input ready);
    modport sink (input valid, input operation, input thread_id, output ready);
endinterface

`default_nettype wire

FILE: src/trq_rsp_if.sv
// result channel of the run queue
`default_nettype none

interface trq_rsp_if;
    logic                      valid;
    logic                      ready;
    logic                      accepted;
    logic [trq_pkg::TID_W-1:0] granted_thread;
    logic                      from_queue;
    logic [trq_pkg::LEN_W-1:0] queue_length;

    modport source (output valid, output accepted, output granted_thread,
                    output from_queue, output queue_length, input ready);
    modport sink (input valid, input accepted, input granted_thread,
                  input from_queue, input queue_length, output ready);
endinterface

`default_nettype wire

FILE: src/trq_ram.sv
// generic single-port-write, single-port-read ram with registered read
`default_nettype none

module trq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: src/trq_clear.sv
// sweep that zeroes the queued map after reset
`default_nettype none

module trq_clear (
    input  wire logic          clk,
    input  wire logic          rst_n,
    output trq_pkg::clr_t      clr
);

    logic [trq_pkg::ID_W-1:0] idx_reg;
    logic [trq_pkg::ID_W-1:0] idx_next;
    logic                     done_reg;
    logic                     done_next;

    always_comb
    begin
        idx_next  = idx_reg;
        done_next = done_reg;
        if (!done_reg)
        begin
            if (idx_reg == trq_pkg::ID_W'(trq_pkg::THREADS - 1))
            begin
                done_next = 1'b1;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            idx_reg  <= idx_next;
            done_reg <= done_next;
        end
    end

    assign clr.busy  = !done_reg;
    assign clr.wr_en = !done_reg;
    assign clr.addr  = idx_reg;

endmodule

`default_nettype wire

FILE: src/thread_run_queue.sv
// run queue: result registered at write-back, after the request and its ram reads
// no new request until the previous one writes back: read-modify-write of the map ram
// a result waiting in the output register does not block taking the next request
// reset: rst_n clears control state, then a sweep over every entry zeroes the queued map
// ready stays low during that sweep; idle_thread writes are taken at any time
`default_nettype none

`include "thread_run_queue_macros.svh"

module thread_run_queue (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    trq_req_if.sink                          req,
    trq_rsp_if.source                        rsp,
    input  wire logic                        cfg_wr_en,
    input  wire logic [trq_pkg::IDLE_W-1:0]  cfg_wr_data
);

    // idle thread register
    logic [trq_pkg::IDLE_W-1:0] idle_reg;

    // ring pointers
    logic [trq_pkg::ID_W-1:0]   head_reg;
    logic [trq_pkg::ID_W-1:0]   head_next;
    logic [trq_pkg::ID_W-1:0]   count_reg;
    logic [trq_pkg::ID_W-1:0]   count_next;

    // request held while its ram reads come back
    logic                       busy_reg;
    logic                       busy_next;
    trq_pkg::op_t               op_reg;
    logic [trq_pkg::TID_W-1:0]  id_reg;
    logic                       id_ok_reg;

    // output register
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic                       acc_reg;
    logic [trq_pkg::TID_W-1:0]  grant_reg;
    logic                       fromq_reg;
    logic [trq_pkg::LEN_W-1:0]  len_reg;

    // ram read data
    logic                       map_q;
    logic [trq_pkg::TID_W-1:0]  slot_q;

    // request-side writes
    logic                       map_we_op;
    logic [trq_pkg::ID_W-1:0]   map_waddr_op;
    logic                       map_wdata_op;
    logic                       map_we;
    logic [trq_pkg::ID_W-1:0]   map_waddr;
    logic                       map_wdata;
    logic                       ring_we;
    logic [trq_pkg::ID_W-1:0]   ring_waddr;

    logic                       acc_next;
    logic [trq_pkg::TID_W-1:0]  grant_next;
    logic                       fromq_next;

    logic                       accept;
    logic                       commit;
    logic                       push_ok;
    logic [trq_pkg::ID_W:0]     back_sum;
    logic [trq_pkg::ID_W-1:0]   back_pos;
    logic [trq_pkg::ID_W-1:0]   front_pos;
    logic [trq_pkg::ID_W-1:0]   head_inc;

    trq_pkg::clr_t              clr;

    // map clearing sweep after reset
    trq_clear u_clear (
        .clk   (clk),
        .rst_n (rst_n),
        .clr   (clr)
    );

    // interlock: a request is taken only once the previous one has written back,
    // so the reads never see a stale entry
    assign req.ready = !clr.busy && !busy_reg;
    assign accept    = req.valid && req.ready;

    // write back when the output register is free or being emptied
    assign commit    = busy_reg && (!out_valid_reg || rsp.ready);

    // ring positions
    assign back_sum  = {1'b0, head_reg} + {1'b0, count_reg};
    assign back_pos  = (back_sum >= (trq_pkg::ID_W + 1)'(trq_pkg::THREADS))
                     ? trq_pkg::ID_W'(back_sum - (trq_pkg::ID_W + 1)'(trq_pkg::THREADS))
                     : trq_pkg::ID_W'(back_sum);
    assign front_pos = (head_reg == '0) ? trq_pkg::ID_W'(trq_pkg::THREADS - 1)
                                        : head_reg - 1'b1;
    assign head_inc  = (head_reg == trq_pkg::ID_W'(trq_pkg::THREADS - 1))
                     ? '0 : head_reg + 1'b1;

    // a push needs a legal id not yet queued; the ring cannot be full
    // since every queued id is distinct and non-zero
    assign push_ok   = id_ok_reg && !map_q && (32'(count_reg) < trq_pkg::THREADS);

    always_comb
    begin
        head_next    = head_reg;
        count_next   = count_reg;
        ring_we      = 1'b0;
        ring_waddr   = back_pos;
        map_we_op    = 1'b0;
        map_waddr_op = trq_pkg::ID_W'(id_reg);
        map_wdata_op = 1'b1;
        acc_next     = 1'b0;
        grant_next   = '0;
        fromq_next   = 1'b0;
        if (commit)
        begin
            unique case (op_reg)
                trq_pkg::OP_PUSH_BACK:
                begin
                    if (push_ok)
                    begin
                        ring_we    = 1'b1;
                        map_we_op  = 1'b1;
                        count_next = count_reg + 1'b1;
                        acc_next   = 1'b1;
                    end
                end
                trq_pkg::OP_PUSH_FRONT:
                begin
                    if (push_ok)
                    begin
                        ring_we    = 1'b1;
                        ring_waddr = front_pos;
                        head_next  = front_pos;
                        map_we_op  = 1'b1;
                        count_next = count_reg + 1'b1;
                        acc_next   = 1'b1;
                    end
                end
                trq_pkg::OP_SCHEDULE:
                begin
                    if (count_reg != '0)
                    begin
                        // pop the front slot and drop its queued mark
                        grant_next   = slot_q;
                        map_we_op    = 1'b1;
                        map_waddr_op = trq_pkg::ID_W'(slot_q);
                        map_wdata_op = 1'b0;
                        head_next    = head_inc;
                        count_next   = count_reg - 1'b1;
                        acc_next     = 1'b1;
                        fromq_next   = 1'b1;
                    end
                    else
                    begin
                        grant_next = trq_pkg::TID_W'(idle_reg);
                    end
                end
                default:
                begin
                    // unused code: nothing changes, length only
                end
            endcase
        end
    end

    // sweep owns the map write port until it is done
    assign map_we    = clr.wr_en || map_we_op;
    assign map_waddr = clr.busy ? clr.addr : map_waddr_op;
    assign map_wdata = clr.busy ? 1'b0 : map_wdata_op;

    // queued map: read at the pushed id, written on commit
    trq_ram #(
        .WIDTH (1),
        .DEPTH (trq_pkg::THREADS)
    ) u_map_ram (
        .clk     (clk),
        .wr_en   (map_we),
        .wr_addr (map_waddr),
        .wr_data (map_wdata),
        .rd_en   (accept),
        .rd_addr (trq_pkg::ID_W'(req.thread_id)),
        .rd_data (map_q)
    );

    // ring slots: read at the head, written at back or new front
    trq_ram #(
        .WIDTH (trq_pkg::TID_W),
        .DEPTH (trq_pkg::THREADS)
    ) u_ring_ram (
        .clk     (clk),
        .wr_en   (ring_we),
        .wr_addr (ring_waddr),
        .wr_data (id_reg),
        .rd_en   (accept),
        .rd_addr (head_reg),
        .rd_data (slot_q)
    );

    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (commit)
        begin
            busy_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_reg      <= '0;
            head_reg      <= '0;
            count_reg     <= '0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                idle_reg <= cfg_wr_data;
            end
            head_reg      <= head_next;
            count_reg     <= count_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload: held request and result
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= trq_pkg::op_t'(req.operation);
            id_reg    <= req.thread_id;
            id_ok_reg <= (req.thread_id != '0)
                      && (32'(req.thread_id) < trq_pkg::THREADS);
        end
        if (commit)
        begin
            acc_reg   <= acc_next;
            grant_reg <= grant_next;
            fromq_reg <= fromq_next;
            len_reg   <= trq_pkg::LEN_W'(count_next);
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.accepted       = acc_reg;
    assign rsp.granted_thread = grant_reg;
    assign rsp.from_queue     = fromq_reg;
    assign rsp.queue_length   = len_reg;

    `TRQ_ASSERT_NEXT(a_interlock, accept, busy_reg && !req.ready,
        "request taken while previous one still in flight")
    `TRQ_ASSERT_NOW(a_no_req_in_sweep, clr.busy, !busy_reg && !map_we_op && !ring_we,
        "request activity during map clearing sweep")
    `TRQ_ASSERT_NEXT(a_pop_count, commit && fromq_next,
        count_reg == trq_pkg::ID_W'($past(count_reg) - 1'b1),
        "queue pop did not reduce the count by one")
    `TRQ_ASSERT_NOW(a_push_nonzero, commit && acc_next && !fromq_next, id_reg != '0,
        "thread zero accepted into the queue")

endmodule

`default_nettype wire
